FILE: src/cass_pkg.sv
// ----------------------------------------------------------------------------
// cass_pkg
// Shared widths, codes and defaults for the automaton state step block.
// ----------------------------------------------------------------------------
package cass_pkg;

    localparam int SLOT_W     = 6;
    localparam int SYM_W      = 8;
    localparam int GOTO_W     = 18;
    localparam int STATE_W    = 20;
    localparam int COUNT_W    = 7;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 20;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 24;

    localparam int MAX_TRANSITIONS_DEF = 64;

    typedef enum logic {
        CMD_LOAD   = 1'b0,
        CMD_LOOKUP = 1'b1
    } cmd_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_FAILURE_TARGET   = 1'b0,
        REG_TRANSITION_COUNT = 1'b1
    } reg_idx_t;

endpackage

FILE: src/cass_ram.sv
// ----------------------------------------------------------------------------
// cass_ram
// Generic single-write, single-read RAM with a registered read.
// ----------------------------------------------------------------------------
module cass_ram #(
    parameter  int WIDTH  = 8,
    parameter  int DEPTH  = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/compressed_automaton_state_step.sv
// ----------------------------------------------------------------------------
// compressed_automaton_state_step
// One automaton state: transition entries in a RAM, scanned in order on lookup.
// ----------------------------------------------------------------------------
// channel   dir  handshake        tdata                          tuser
// s_        in   tvalid/tready    slot, symbol, goto target      cmd
// m_        out  tvalid/tready    next state (zero padded)       found
// cfg_      in   cfg_we           failure target or count        -
//
// A load writes its entry on acceptance. A lookup reads k entries, k being
// those up to the first match, at most min(transition_count, MAX_TRANSITIONS);
// the single RAM read port yields one entry per cycle. A zero count answers
// in the cycle after acceptance. Reset is synchronous and clears control
// state; RAM contents stay undefined until loaded. A stalled result holds
// the scan and blocks new items.
// ----------------------------------------------------------------------------
module compressed_automaton_state_step #(
    parameter int MAX_TRANSITIONS = cass_pkg::MAX_TRANSITIONS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [cass_pkg::S_TDATA_W-1:0]   s_tdata,  // entry_slot, symbol, goto_target
    input  logic                             s_tuser,  // cmd
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [cass_pkg::M_TDATA_W-1:0]   m_tdata,  // next_state, zero pad
    output logic                             m_tuser,  // found
    input  logic                             cfg_we,
    input  logic [cass_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [cass_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int ADDR_W  = (MAX_TRANSITIONS > 1) ? $clog2(MAX_TRANSITIONS) : 1;
    localparam int CMP_W   = ((ADDR_W > cass_pkg::COUNT_W) ? ADDR_W : cass_pkg::COUNT_W) + 2;
    localparam int ENTRY_W = cass_pkg::SYM_W + cass_pkg::GOTO_W;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t                         state_reg, state_next;
    logic [ADDR_W-1:0]              idx_reg, idx_next;
    logic [CMP_W-1:0]               limit_reg, limit_next;
    logic [cass_pkg::SYM_W-1:0]     sym_reg, sym_next;
    logic                           m_valid_reg, m_valid_next;
    logic                           m_found_reg, m_found_next;
    logic [cass_pkg::STATE_W-1:0]   m_state_reg, m_state_next;
    logic [cass_pkg::STATE_W-1:0]   fail_reg;
    logic [cass_pkg::COUNT_W-1:0]   count_reg;

    logic [cass_pkg::SLOT_W-1:0]    in_slot;
    logic [cass_pkg::SYM_W-1:0]     in_sym;
    logic [cass_pkg::GOTO_W-1:0]    in_goto;
    logic                           s_accept;
    logic                           is_lookup;
    logic                           out_busy;
    logic [CMP_W-1:0]               cnt_ext;
    logic [CMP_W-1:0]               max_ext;
    logic [CMP_W-1:0]               lim_now;
    logic                           slot_ok;

    logic                           ram_we;
    logic [ADDR_W-1:0]              ram_raddr;
    logic [ENTRY_W-1:0]             ram_rdata;
    logic [cass_pkg::SYM_W-1:0]     rd_sym;
    logic [cass_pkg::GOTO_W-1:0]    rd_goto;
    logic [ADDR_W-1:0]              idx_inc;
    logic                           hit;
    logic                           last;
    logic                           done;

    assign in_slot   = s_tdata[cass_pkg::SLOT_W-1:0];
    assign in_sym    = s_tdata[cass_pkg::SLOT_W +: cass_pkg::SYM_W];
    assign in_goto   = s_tdata[cass_pkg::SLOT_W + cass_pkg::SYM_W +: cass_pkg::GOTO_W];
    assign is_lookup = (cass_pkg::cmd_t'(s_tuser) == cass_pkg::CMD_LOOKUP);

    assign out_busy  = m_valid_reg && !m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && !out_busy;
    assign s_accept  = s_tvalid && s_tready;

    assign cnt_ext   = CMP_W'(count_reg);
    assign max_ext   = CMP_W'(MAX_TRANSITIONS);
    assign lim_now   = (cnt_ext > max_ext) ? max_ext : cnt_ext;
    assign slot_ok   = (CMP_W'(in_slot) < max_ext);

    assign ram_we    = s_accept && !is_lookup && slot_ok;
    assign rd_sym    = ram_rdata[cass_pkg::SYM_W-1:0];
    assign rd_goto   = ram_rdata[cass_pkg::SYM_W +: cass_pkg::GOTO_W];
    assign idx_inc   = idx_reg + ADDR_W'(1);
    assign hit       = (rd_sym == sym_reg);
    assign last      = ((CMP_W'(idx_reg) + CMP_W'(1)) == limit_reg);
    assign done      = hit || last;

    always_comb begin
        unique case (state_reg)
            ST_IDLE: ram_raddr = '0;
            ST_SCAN: ram_raddr = (done && out_busy) ? idx_reg : idx_inc;
            default: ram_raddr = '0;
        endcase
    end

    cass_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_TRANSITIONS)
    ) u_entry_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ADDR_W'(in_slot)),
        .wr_data ({in_goto, in_sym}),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        limit_next   = limit_reg;
        sym_next     = sym_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_found_next = m_found_reg;
        m_state_next = m_state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept && is_lookup) begin
                    sym_next   = in_sym;
                    limit_next = lim_now;
                    idx_next   = '0;
                    if (lim_now == '0) begin
                        m_valid_next = 1'b1;
                        m_found_next = 1'b0;
                        m_state_next = fail_reg;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (done) begin
                    if (!out_busy) begin
                        m_valid_next = 1'b1;
                        m_found_next = hit;
                        m_state_next = hit ? cass_pkg::STATE_W'(rd_goto) : fail_reg;
                        state_next   = ST_IDLE;
                    end
                end else begin
                    idx_next = idx_inc;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            fail_reg    <= '0;
            count_reg   <= '0;
            idx_reg     <= '0;
            limit_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            idx_reg     <= idx_next;
            limit_reg   <= limit_next;
            if (cfg_we) begin
                unique case (cass_pkg::reg_idx_t'(cfg_addr))
                    cass_pkg::REG_FAILURE_TARGET:
                        fail_reg <= cfg_wdata[cass_pkg::STATE_W-1:0];
                    cass_pkg::REG_TRANSITION_COUNT:
                        count_reg <= cfg_wdata[cass_pkg::COUNT_W-1:0];
                    default: ;
                endcase
            end
        end
        sym_reg     <= sym_next;
        m_found_reg <= m_found_next;
        m_state_reg <= m_state_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_found_reg;
    assign m_tdata  = cass_pkg::M_TDATA_W'(m_state_reg);

    a_ready_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> state_reg == ST_IDLE)
        else $error("item taken outside idle");

    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> CMP_W'(idx_reg) < limit_reg)
        else $error("scan index beyond limit");

    a_zero_limit_fails: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && is_lookup && lim_now == '0) |=> m_valid_reg && !m_found_reg)
        else $error("empty lookup did not fail at once");

    a_fail_carries_target: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_found_reg) |-> m_state_reg == fail_reg)
        else $error("failure result without failure target");

endmodule
